// ===== hdl/cihv_pkg.sv =====
package cihv_pkg;

    // Layout of the fixed file head
    localparam int MAGIC_LEN  = 4;
    localparam int FIXED_PART = 36;

    // Characters the parser looks for
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_I    = 8'h49;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Fault codes reported with each file
    localparam logic [2:0] FAULT_NONE      = 3'd0;
    localparam logic [2:0] FAULT_MAGIC     = 3'd1;
    localparam logic [2:0] FAULT_CONTENT   = 3'd2;
    localparam logic [2:0] FAULT_CAPTION   = 3'd3;
    localparam logic [2:0] FAULT_NO_TAG    = 3'd4;
    localparam logic [2:0] FAULT_HDR_SIZE  = 3'd5;
    localparam logic [2:0] FAULT_PIXELS    = 3'd6;
    localparam logic [2:0] FAULT_TRUNCATED = 3'd7;

    // What the back end has to do with one byte
    typedef enum logic [2:0] {
        OP_NONE,
        OP_HDR,
        OP_CONTENT,
        OP_WIDTH,
        OP_HEIGHT,
        OP_BODY
    } t_op_kind;

    // One classified byte, as queued between front and back
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic [2:0] k;          // byte lane inside a little-endian field
        logic       last;       // final byte of the file
        logic       magic_bad;  // magic mismatch seen up to and including this byte
    } t_op;

    // Expected magic byte at head position idx
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = CH_C;
            2'd1:    r = CH_I;
            default: r = CH_F;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/cihv_front.sv =====
module cihv_front #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_final_byte,
    input  logic                   i_full,
    output logic                   o_stall,
    output logic                   o_push,
    output cihv_pkg::t_op          o_op,
    output logic [COUNT_WIDTH-1:0] o_pos
);
    import cihv_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] POS_MAX = '1;

    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic                   r_magic_ok;
    logic [63:0]            r_hdr, n_hdr;
    logic [5:0]             idx;
    logic                   mismatch;
    logic                   accept;
    t_op                    op;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept;
    assign o_op    = op;
    assign o_pos   = r_pos;

    // Classify the byte by its position in the file
    always_comb begin
        idx      = r_pos[5:0] - 6'(MAGIC_LEN);
        mismatch = 1'b0;
        op.kind  = OP_NONE;
        op.data  = i_data_byte;
        op.k     = idx[2:0];
        op.last  = i_final_byte;
        if (r_pos < COUNT_WIDTH'(MAGIC_LEN)) begin
            mismatch = (i_data_byte != magic_byte(r_pos[1:0]));
        end else if (r_pos < COUNT_WIDTH'(FIXED_PART)) begin
            case (idx[4:3])
                2'd0:    op.kind = OP_HDR;
                2'd1:    op.kind = OP_CONTENT;
                2'd2:    op.kind = OP_WIDTH;
                default: op.kind = OP_HEIGHT;
            endcase
        end else if (64'(r_pos) < r_hdr) begin
            op.kind = OP_BODY;
        end
        op.magic_bad = !r_magic_ok || mismatch;

        n_hdr = r_hdr;
        if (op.kind == OP_HDR) begin
            n_hdr = r_hdr | (64'(i_data_byte) << {idx[2:0], 3'b000});
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;
    end

    // Position, magic status and header length of the current file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_magic_ok <= 1'b1;
            r_hdr      <= '0;
        end else if (accept) begin
            if (i_final_byte) begin
                r_pos      <= '0;
                r_magic_ok <= 1'b1;
                r_hdr      <= '0;
            end else begin
                r_pos      <= n_pos;
                r_magic_ok <= !op.magic_bad;
                r_hdr      <= n_hdr;
            end
        end
    end

endmodule

// ===== hdl/cihv_queue.sv =====
module cihv_queue #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 4     // power of two
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue written while full");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue read while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a transaction");

endmodule

// ===== hdl/cihv_back.sv =====
module cihv_back #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  cihv_pkg::t_op          i_op,
    input  logic [COUNT_WIDTH-1:0] i_pos,
    output logic                   o_pop,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic                   o_file_valid,
    output logic [2:0]             o_fault_code,
    output logic [62:0]            o_image_width,
    output logic [62:0]            o_image_height
);
    import cihv_pkg::*;

    localparam logic [COUNT_WIDTH-1:0] POS_MAX = '1;

    typedef struct packed {
        logic trunc;
        logic magic_bad;
        logic cap_miss;
        logic tag_miss;
        logic hdr_bad;
        logic pix_bad;
    } t_checks;

    logic en;

    // Stage 1 state: decoded fields and caption/tag scan
    logic [63:0] r_hdr, r_content, r_width, r_height, r_lt;
    logic        r_cap, r_tag;
    logic [63:0] n_hdr, n_content, n_width, n_height, n_lt;
    logic        n_cap, n_tag;
    logic [63:0] v, p_ext, total64;
    logic [COUNT_WIDTH-1:0] total;
    t_checks     chk;

    // Stage 1 -> 2 registers
    logic        r_m_valid;
    logic [71:0] r_m_prod;
    logic [2:0]  r_m_k;
    logic        r_s_valid;
    t_checks     r_s_chk;
    logic [63:0] r_s_content;
    logic [62:0] r_s_width, r_s_height;

    // Stage 2 accumulator and stage 2 -> 3 registers
    logic [63:0]  r_acc, n_acc;
    logic         r_ovf, n_ovf;
    logic [127:0] sh;
    logic         term_ovf;
    logic [64:0]  sum;
    logic         r_f_valid;
    logic [63:0]  r_f_acc, r_f_content;
    logic         r_f_ovf;
    t_checks      r_f_chk;
    logic [62:0]  r_f_width, r_f_height;

    // Stage 3
    logic [65:0] prod3;
    logic        prod_bad;
    logic [2:0]  fault;

    // Output register
    logic        r_out_valid, r_out_file_valid;
    logic [2:0]  r_out_fault;
    logic [62:0] r_out_width, r_out_height;

    // The whole back pipeline advances unless the output is held
    assign en    = !r_out_valid || !i_stall;
    assign o_pop = en && !i_empty;

    // Stage 1: field decode, caption and tag scan, end-of-file checks
    always_comb begin
        v         = 64'(i_op.data) << {i_op.k, 3'b000};
        p_ext     = 64'(i_pos);
        n_hdr     = r_hdr;
        n_content = r_content;
        n_width   = r_width;
        n_height  = r_height;
        n_lt      = r_lt;
        n_cap     = r_cap;
        n_tag     = r_tag;
        case (i_op.kind)
            OP_HDR:     n_hdr     = r_hdr | v;
            OP_CONTENT: n_content = r_content | v;
            OP_WIDTH:   n_width   = r_width | v;
            OP_HEIGHT:  n_height  = r_height | v;
            OP_BODY: begin
                if (!r_cap) begin
                    if (i_op.data == CH_LF) begin
                        n_cap = 1'b1;
                        n_lt  = p_ext + 64'd1;
                    end
                end else if (i_op.data == CH_NUL) begin
                    n_tag = 1'b1;
                    n_lt  = p_ext + 64'd1;
                end
            end
            default: ;
        endcase

        total         = (i_pos == POS_MAX) ? i_pos : i_pos + 1'b1;
        total64       = 64'(total);
        chk.trunc     = (total64 < 64'(FIXED_PART)) || (total64 < n_hdr);
        chk.magic_bad = i_op.magic_bad;
        chk.cap_miss  = !n_cap;
        chk.tag_miss  = !n_tag;
        chk.hdr_bad   = (n_hdr != n_lt);
        chk.pix_bad   = (total == POS_MAX) || ((total64 - n_hdr) != n_content);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr     <= '0;
            r_content <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_lt      <= '0;
            r_cap     <= 1'b0;
            r_tag     <= 1'b0;
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= o_pop && (i_op.kind == OP_HEIGHT);
            r_s_valid <= o_pop && i_op.last;
            if (o_pop) begin
                if (i_op.last) begin
                    r_hdr     <= '0;
                    r_content <= '0;
                    r_width   <= '0;
                    r_height  <= '0;
                    r_lt      <= '0;
                    r_cap     <= 1'b0;
                    r_tag     <= 1'b0;
                end else begin
                    r_hdr     <= n_hdr;
                    r_content <= n_content;
                    r_width   <= n_width;
                    r_height  <= n_height;
                    r_lt      <= n_lt;
                    r_cap     <= n_cap;
                    r_tag     <= n_tag;
                end
            end
        end
    end

    // Stage 1 payload: partial product and end-of-file snapshot
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod    <= 72'(r_width) * 72'(i_op.data);
            r_m_k       <= i_op.k;
            r_s_chk     <= chk;
            r_s_content <= n_content;
            r_s_width   <= n_width[62:0];
            r_s_height  <= n_height[62:0];
        end
    end

    // Stage 2: add width * height byte at its lane, tracking overflow
    always_comb begin
        sh       = 128'(r_m_prod) << {r_m_k, 3'b000};
        term_ovf = |sh[127:64];
        sum      = 65'(r_acc) + 65'(sh[63:0]);
        n_acc    = r_acc;
        n_ovf    = r_ovf;
        if (r_m_valid) begin
            n_ovf = r_ovf || term_ovf || sum[64];
            if (!term_ovf) begin
                n_acc = sum[63:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_ovf     <= 1'b0;
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_s_valid;
            if (r_s_valid) begin
                r_acc <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_ovf <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_acc     <= n_acc;
            r_f_ovf     <= n_ovf;
            r_f_content <= r_s_content;
            r_f_chk     <= r_s_chk;
            r_f_width   <= r_s_width;
            r_f_height  <= r_s_height;
        end
    end

    // Stage 3: product times three against content size, fault priority
    always_comb begin
        prod3    = 66'(r_f_acc) + 66'({r_f_acc, 1'b0});
        prod_bad = r_f_ovf || (prod3[65:64] != 2'b00) || (prod3[63:0] != r_f_content);
        if (r_f_chk.trunc) begin
            fault = FAULT_TRUNCATED;
        end else if (r_f_chk.magic_bad) begin
            fault = FAULT_MAGIC;
        end else if (prod_bad) begin
            fault = FAULT_CONTENT;
        end else if (r_f_chk.cap_miss) begin
            fault = FAULT_CAPTION;
        end else if (r_f_chk.tag_miss) begin
            fault = FAULT_NO_TAG;
        end else if (r_f_chk.hdr_bad) begin
            fault = FAULT_HDR_SIZE;
        end else if (r_f_chk.pix_bad) begin
            fault = FAULT_PIXELS;
        end else begin
            fault = FAULT_NONE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_f_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_file_valid <= (fault == FAULT_NONE);
            r_out_fault      <= fault;
            r_out_width      <= r_f_width;
            r_out_height     <= r_f_height;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_file_valid   = r_out_file_valid;
    assign o_fault_code   = r_out_fault;
    assign o_image_width  = r_out_width;
    assign o_image_height = r_out_height;

    a_snap_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s_valid) |=> r_f_valid)
        else $error("end-of-file snapshot dropped between stages");
    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s_valid) |=> (r_acc == '0 && !r_ovf))
        else $error("product accumulator not cleared after end of file");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_f_valid) && $stable(r_s_valid) && $stable(r_acc)))
        else $error("back pipeline moved while output held");

endmodule

// ===== hdl/ciff_image_header_validator.sv =====
// CIFF image header validator: one file byte per transaction, one result per file.
// Throughput: one byte per clock while the queue is not full, sustained across file boundaries.
// Path: a file's final byte passes through the queue, then the decode stage, the product
// accumulate stage and fault select into the output register. A stalled result holds the
// back end; the input stalls only once the 4-entry queue is full.
// Reset: i_rst_n synchronous, active low; clears queue, pipeline valids and parse state.
module ciff_image_header_validator #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_file_valid,
    output logic [2:0]  o_fault_code,
    output logic [62:0] o_image_width,
    output logic [62:0] o_image_height
);
    import cihv_pkg::*;

    localparam int Q_WIDTH = $bits(t_op) + COUNT_WIDTH;

    logic                   push, pop, full, empty;
    t_op                    f_op, b_op;
    logic [COUNT_WIDTH-1:0] f_pos, b_pos;
    logic [Q_WIDTH-1:0]     q_out;

    // Front end: position tracking and byte classification
    cihv_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_final_byte (i_final_byte),
        .i_full       (full),
        .o_stall      (o_stall),
        .o_push       (push),
        .o_op         (f_op),
        .o_pos        (f_pos)
    );

    // Decoupling queue
    cihv_queue #(.WIDTH(Q_WIDTH), .DEPTH(4)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_pos, f_op}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign b_op  = q_out[$bits(t_op)-1:0];
    assign b_pos = q_out[Q_WIDTH-1:$bits(t_op)];

    // Back end: field decode, product, checks and result
    cihv_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .i_op           (b_op),
        .i_pos          (b_pos),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_file_valid   (o_file_valid),
        .o_fault_code   (o_fault_code),
        .o_image_width  (o_image_width),
        .o_image_height (o_image_height)
    );

endmodule
